>>> hdl/tat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_pkg
// Types and constants shared by the TLB address translator modules.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int TLB_DEPTH = 32;
    localparam int SLOT_W    = $clog2(TLB_DEPTH);
    localparam int CNT_W     = $clog2(TLB_DEPTH + 1);
    localparam int PSIZE_W   = 17;
    localparam int ADDR_W    = 32;
    localparam int DIV_STEPS = ADDR_W;

    localparam logic [1:0] CFG_TLB_ENTRIES    = 2'd0;
    localparam logic [1:0] CFG_REPLACE_POLICY = 2'd1;
    localparam logic [1:0] CFG_PAGE_SIZE      = 2'd2;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic [15:0] process_id;
        logic [31:0] logical_address;
        logic [15:0] memory_frame;
    } t_in_item;

    typedef struct packed {
        logic [31:0] physical_address;
        logic [15:0] frame_number;
        logic [31:0] page_number;
        logic        tlb_hit;
    } t_out_item;

    typedef struct packed {
        logic [15:0] process_id;
        logic [31:0] page;
        logic [15:0] frame;
        logic [31:0] last_use;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WSTART,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_MUL,
        S_OUT
    } t_state;

endpackage

>>> hdl/tat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tat_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tat_divider
// Restoring divider, one quotient bit per cycle, address by page size.
// ----------------------------------------------------------------------------
module tat_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tat_pkg::ADDR_W-1:0]  i_dividend,
    input  logic [tat_pkg::PSIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [tat_pkg::ADDR_W-1:0]  o_quot,
    output logic [tat_pkg::PSIZE_W-1:0] o_rem
);
    import tat_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic [STEP_W-1:0]  r_count;
    logic [ADDR_W-1:0]  r_quot;
    logic [PSIZE_W-1:0] r_rem;
    logic               r_done;
    logic [PSIZE_W:0]   trial;
    logic               fits;

    assign trial = {r_rem, r_quot[ADDR_W-1]};
    assign fits  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_count <= STEP_W'(DIV_STEPS);
            end else if (r_count != '0) begin
                r_count <= r_count - 1'b1;
                if (r_count == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_count != '0) begin
            r_quot <= {r_quot[ADDR_W-2:0], fits};
            r_rem  <= fits ? PSIZE_W'(trial - {1'b0, i_divisor}) : trial[PSIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> hdl/tlb_address_translator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_address_translator_unit
// Translates (process id, logical address) to a physical address via a TLB.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall / i_in_data carries one access;
//   output channel o_out_valid / i_out_stall / o_out_data returns one result
//   per access. Configuration is written through i_cfg_we / i_cfg_index /
//   i_cfg_data, by the user only while the block is idle; the block itself
//   does not enforce this. One access at a time: o_in_stall is low only
//   while the sequencer idles. Each access runs the bit-serial page divide,
//   a setup state, then S_RD and S_CMP per TLB entry compared (entries read
//   one at a time from the entry RAM, the walk stops at a hit), then
//   insert/stamp, multiply and output load. With the TLB disabled the
//   walk and the insert/stamp step are skipped, and an empty TLB skips
//   the walk only. The result sits in an output register; the next access
//   is taken while it waits. A stalled receiver holds the block in its
//   output state only when a second result is ready and the register is
//   still full. Reset empties the TLB (fill count, FIFO pointer and use
//   counter cleared) and loads 4 entries, FIFO policy and page size 64.
// ----------------------------------------------------------------------------
module tlb_address_translator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tat_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tat_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tat_pkg::PSIZE_W-1:0] i_cfg_data
);
    import tat_pkg::*;

    // configuration
    logic [5:0]         r_tlb_entries;
    logic               r_policy;
    logic [PSIZE_W-1:0] r_page_size;

    // tlb bookkeeping
    logic [CNT_W-1:0]  r_filled;
    logic [SLOT_W-1:0] r_oldest;
    logic [31:0]       r_use_cnt;

    // per-access registers
    t_state             r_state, n_state;
    t_in_item           r_item;
    logic [PSIZE_W-1:0] r_psize;
    logic [CNT_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  r_page;
    logic [PSIZE_W-1:0] r_offset;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_victim;
    logic [31:0]        r_min;
    t_entry             r_hit_entry;
    logic [15:0]        r_frame;
    logic [31:0]        r_phys;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_xfer;
    logic               div_done;
    logic [ADDR_W-1:0]  div_quot;
    logic [PSIZE_W-1:0] div_rem;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    t_entry             ram_rdata;
    logic               match;
    logic [CNT_W-1:0]   cap_in;
    logic [CNT_W-1:0]   used_w;
    logic [32:0]        prod;
    logic               out_free;
    logic [SLOT_W-1:0]  ins_slot;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign cap_in = (r_tlb_entries > 6'(TLB_DEPTH)) ? CNT_W'(TLB_DEPTH)
                                                    : CNT_W'(r_tlb_entries);
    assign used_w = (r_filled > r_cap) ? r_cap : r_filled;

    assign match = (ram_rdata.process_id == r_item.process_id) &&
                   (ram_rdata.page == r_page);

    // victim for a miss
    always_comb begin
        if (r_used < r_cap) begin
            ins_slot = r_used[SLOT_W-1:0];
        end else if (r_policy == POLICY_FIFO) begin
            ins_slot = (CNT_W'(r_oldest) < r_cap) ? r_oldest : '0;
        end else begin
            ins_slot = r_victim;
        end
    end

    assign ram_we    = (r_state == S_DECIDE) && (!r_found || r_policy == POLICY_LRU);
    assign ram_waddr = r_found ? r_slot : ins_slot;
    always_comb begin
        if (r_found) begin
            ram_wdata          = r_hit_entry;
            ram_wdata.last_use = r_use_cnt;
        end else begin
            ram_wdata.process_id = r_item.process_id;
            ram_wdata.page       = r_page;
            ram_wdata.frame      = r_item.memory_frame;
            ram_wdata.last_use   = r_use_cnt;
        end
    end

    assign prod = r_psize * r_frame;

    tat_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_dividend (i_in_data.logical_address),
        .i_divisor  ((r_page_size == '0) ? PSIZE_W'(1) : r_page_size),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    tat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TLB_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_WSTART;
            S_WSTART: begin
                if (r_cap == '0) begin
                    n_state = S_MUL;
                end else if (used_w == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD:     n_state = S_CMP;
            S_CMP: begin
                if (match || (r_idx + 1'b1 == r_used)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DECIDE: n_state = S_MUL;
            S_MUL:    n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and tlb control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_entries <= 6'd4;
            r_policy      <= POLICY_FIFO;
            r_page_size   <= PSIZE_W'(64);
            r_filled      <= '0;
            r_oldest      <= '0;
            r_use_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TLB_ENTRIES:    r_tlb_entries <= i_cfg_data[5:0];
                    CFG_REPLACE_POLICY: r_policy      <= i_cfg_data[0];
                    CFG_PAGE_SIZE:      r_page_size   <= i_cfg_data;
                    default:            ;
                endcase
            end
            if (r_state == S_DECIDE) begin
                if (ram_we) begin
                    r_use_cnt <= r_use_cnt + 1'b1;
                end
                if (!r_found) begin
                    r_filled <= (r_used < r_cap) ? r_used + 1'b1 : r_cap;
                    if (r_used >= r_cap && r_policy == POLICY_FIFO) begin
                        r_oldest <= (CNT_W'(ins_slot) + 1'b1 >= r_cap) ? '0
                                                                       : ins_slot + 1'b1;
                    end
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item  <= i_in_data;
            r_psize <= (r_page_size == '0) ? PSIZE_W'(1) : r_page_size;
            r_cap   <= cap_in;
        end
        case (r_state)
            S_DIV: begin
                r_page   <= div_quot;
                r_offset <= div_rem;
            end
            S_WSTART: begin
                r_used  <= used_w;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_frame <= r_item.memory_frame;
                r_min   <= '0;
                r_victim <= '0;
            end
            S_CMP: begin
                if (match) begin
                    r_found     <= 1'b1;
                    r_slot      <= r_idx[SLOT_W-1:0];
                    r_hit_entry <= ram_rdata;
                    r_frame     <= ram_rdata.frame;
                end else begin
                    if (r_idx == '0 || ram_rdata.last_use < r_min) begin
                        r_min    <= ram_rdata.last_use;
                        r_victim <= r_idx[SLOT_W-1:0];
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_MUL: begin
                r_phys <= prod[31:0] + 32'(r_offset);
            end
            S_OUT: begin
                if (out_free) begin
                    r_out.physical_address <= r_phys;
                    r_out.frame_number     <= r_frame;
                    r_out.page_number      <= r_page;
                    r_out.tlb_hit          <= r_found && (r_cap != '0);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(TLB_DEPTH))
        else $error("fill count beyond tlb depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx < r_used))
        else $error("entry walk past used entries");

    a_div_then_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> (r_state == S_WSTART))
        else $error("divider finished outside sequence");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_out_valid)
        else $error("result not loaded into output register");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tlb_address_translator_unit. A queue of accesses
// feeds a clocked driver; a clocked monitor checks every result against an
// internal TLB translation model, over phases with different configurations.
// ----------------------------------------------------------------------------
module tb;
    import tat_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_TLB_ENTRIES;
    logic [PSIZE_W-1:0] cfg_data = '0;

    tlb_address_translator_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // translation model state
    logic [5:0]  m_entries;
    logic        m_policy;
    logic [16:0] m_psize;
    logic [15:0] tlb_pid [TLB_DEPTH];
    logic [31:0] tlb_page [TLB_DEPTH];
    logic [15:0] tlb_frame [TLB_DEPTH];
    logic [31:0] tlb_stamp [TLB_DEPTH];
    int unsigned fill_cnt, fifo_ptr;
    logic [31:0] stamp_cnt;

    t_in_item  pending_access[$];
    t_out_item expected_xlat[$];
    int  mismatches = 0;
    bit  quiet = 1'b0;
    int  hold_off = 0;
    int  send_gap = 0, recv_gap = 0;

    function automatic t_out_item translate(t_in_item a);
        t_out_item r;
        int unsigned ps, cap, used, slot;
        logic [31:0] page, offset;
        logic [15:0] frame;
        bit found;
        ps = (m_psize == 0) ? 1 : m_psize;
        page = a.logical_address / ps;
        offset = a.logical_address - page * ps;
        cap = (m_entries > TLB_DEPTH) ? TLB_DEPTH : m_entries;
        frame = a.memory_frame;
        found = 1'b0;
        slot = 0;
        if (cap > 0) begin
            used = (fill_cnt > cap) ? cap : fill_cnt;
            for (int i = 0; i < used; i++) begin
                if (!found && tlb_pid[i] == a.process_id && tlb_page[i] == page) begin
                    found = 1'b1;
                    slot = i;
                end
            end
            if (found) begin
                frame = tlb_frame[slot];
                if (m_policy == POLICY_LRU) begin
                    tlb_stamp[slot] = stamp_cnt;
                    stamp_cnt++;
                end
            end else begin
                if (used < cap) begin
                    slot = used;
                    fill_cnt = used + 1;
                end else if (m_policy == POLICY_FIFO) begin
                    slot = (fifo_ptr < cap) ? fifo_ptr : 0;
                    fifo_ptr = (slot + 1 >= cap) ? 0 : slot + 1;
                    fill_cnt = cap;
                end else begin
                    slot = 0;
                    for (int i = 1; i < cap; i++)
                        if (tlb_stamp[i] < tlb_stamp[slot]) slot = i;
                    fill_cnt = cap;
                end
                tlb_pid[slot] = a.process_id;
                tlb_page[slot] = page;
                tlb_frame[slot] = a.memory_frame;
                tlb_stamp[slot] = stamp_cnt;
                stamp_cnt++;
            end
        end
        r.physical_address = 32'(64'(ps) * 64'(frame) + 64'(offset));
        r.frame_number = frame;
        r.page_number = page;
        r.tlb_hit = found;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            expected_xlat.push_back(translate(in_data));
        end
        if (!in_valid || !in_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_access.size() > 0) begin
                in_data <= pending_access.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter
    always @(posedge clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // monitor and receiver stall
    always @(posedge clk) begin
        t_out_item exp_r;
        if (out_valid && !out_stall) begin
            if (expected_xlat.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %p", out_data);
            end else begin
                exp_r = expected_xlat.pop_front();
                if (out_data.physical_address !== exp_r.physical_address ||
                    out_data.frame_number !== exp_r.frame_number ||
                    out_data.page_number !== exp_r.page_number ||
                    out_data.tlb_hit !== exp_r.tlb_hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_r, out_data);
                end
            end
        end
        if (hold_off > 0) begin
            out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 3);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [PSIZE_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TLB_ENTRIES) m_entries = val[5:0];
        else if (idx == CFG_REPLACE_POLICY) m_policy = val[0];
        else if (idx == CFG_PAGE_SIZE) m_psize = val[16:0];
    endtask

    task automatic drain();
        while (pending_access.size() > 0 || in_valid || expected_xlat.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic t_in_item mk(logic [15:0] p, logic [31:0] a, logic [15:0] f);
        t_in_item t;
        t.process_id = p;
        t.logical_address = a;
        t.memory_frame = f;
        return t;
    endfunction

    // working set of reusable pages so hits and evictions happen
    task automatic random_phase(int n, int pages);
        logic [31:0] base;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8)
                pending_access.push_back(mk(16'($urandom_range(0, 2)),
                    32'($urandom_range(0, pages - 1)) * 32'(m_psize == 0 ? 1 : m_psize)
                        + 32'($urandom_range(0, 3)), 16'($urandom)));
            else begin
                base = $urandom;
                pending_access.push_back(mk(16'($urandom), base, 16'($urandom)));
            end
        end
        drain();
    endtask

    initial begin
        m_entries = 6'd4;
        m_policy = POLICY_FIFO;
        m_psize = 17'd64;
        fill_cnt = 0;
        fifo_ptr = 0;
        stamp_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, hits, FIFO eviction
        pending_access.push_back(mk(16'h0000, 32'h0000_0000, 16'h0000));
        pending_access.push_back(mk(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        pending_access.push_back(mk(16'h0000, 32'h0000_003F, 16'h1234));
        pending_access.push_back(mk(16'hFFFF, 32'hFFFF_FFC0, 16'h0001));
        for (int i = 0; i < 6; i++)
            pending_access.push_back(mk(16'h0007, 32'(i * 64), 16'(i + 100)));
        pending_access.push_back(mk(16'h0007, 32'd0, 16'h5555));
        pending_access.push_back(mk(16'h0007, 32'd320, 16'h5555));
        drain();

        // page size zero acts as one, TLB disabled
        write_reg(CFG_PAGE_SIZE, 17'd0);
        write_reg(CFG_TLB_ENTRIES, 17'd0);
        write_reg(CFG_REPLACE_POLICY, PSIZE_W'(POLICY_LRU));
        pending_access.push_back(mk(16'h0001, 32'hFFFF_FFFF, 16'hFFFF));
        pending_access.push_back(mk(16'h0001, 32'hFFFF_FFFF, 16'h0002));
        drain();

        // LRU with a two-entry TLB, page size 65536
        write_reg(CFG_TLB_ENTRIES, 17'd2);
        write_reg(CFG_PAGE_SIZE, 17'd65536);
        pending_access.push_back(mk(16'h0002, 32'h0001_0000, 16'h0010));
        pending_access.push_back(mk(16'h0002, 32'h0002_0000, 16'h0020));
        pending_access.push_back(mk(16'h0002, 32'h0001_FFFF, 16'h0030));
        pending_access.push_back(mk(16'h0002, 32'h0003_0000, 16'h0040));
        pending_access.push_back(mk(16'h0002, 32'h0001_0001, 16'h0050));
        drain();

        // oversize entry count, then shrunk TLB after fill, FIFO pointer past capacity
        write_reg(CFG_REPLACE_POLICY, PSIZE_W'(POLICY_FIFO));
        write_reg(CFG_TLB_ENTRIES, 17'd63);
        write_reg(CFG_PAGE_SIZE, 17'd1);
        random_phase(120, 40);
        write_reg(CFG_TLB_ENTRIES, 17'd3);
        random_phase(60, 6);

        // long receiver hold-off while the sender keeps offering
        write_reg(CFG_REPLACE_POLICY, PSIZE_W'(POLICY_LRU));
        write_reg(CFG_TLB_ENTRIES, 17'd32);
        write_reg(CFG_PAGE_SIZE, 17'd4096);
        hold_off = 400;
        random_phase(300, 48);
        write_reg(CFG_TLB_ENTRIES, 17'd8);
        write_reg(CFG_PAGE_SIZE, 17'd100);
        random_phase(400, 12);
        write_reg(CFG_REPLACE_POLICY, PSIZE_W'(POLICY_FIFO));
        write_reg(CFG_TLB_ENTRIES, 17'd1);
        write_reg(CFG_PAGE_SIZE, 17'd65535);
        random_phase(300, 3);
        write_reg(CFG_TLB_ENTRIES, 17'd16);
        write_reg(CFG_PAGE_SIZE, 17'd3);
        random_phase(400, 24);
        quiet = 1'b1;
        write_reg(CFG_REPLACE_POLICY, PSIZE_W'(POLICY_LRU));
        write_reg(CFG_PAGE_SIZE, 17'd512);
        random_phase(250, 20);

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb failed");
        $finish;
    end
endmodule

>>> files.f
hdl/tat_pkg.sv
hdl/tat_ram.sv
hdl/tat_divider.sv
hdl/tlb_address_translator_unit.sv
sim/tb.sv
